### design/upe_pkg.sv
// upe_pkg: shared types, character constants and helpers for the URL percent-escape block.
// No dependencies; used by upe_encode, upe_emit and url_percent_escape.
package upe_pkg;

    typedef enum logic [1:0] {
        MODE_PATH     = 2'd0,
        MODE_USERINFO = 2'd1,
        MODE_QUERY    = 2'd2,
        MODE_FRAGMENT = 2'd3
    } escape_mode_t;

    localparam logic [7:0] CHAR_PCT   = 8'h25;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A_UC  = 8'h41;

    // remaining characters of one encoded byte: 0..3
    typedef logic [1:0] char_count_t;

    localparam char_count_t COUNT_NONE   = 2'd0;
    localparam char_count_t COUNT_SINGLE = 2'd1;
    localparam char_count_t COUNT_PAIR   = 2'd2;
    localparam char_count_t COUNT_TRIPLE = 2'd3;

    // one input byte in its encoded form; chars[0] goes out first
    typedef struct packed {
        logic [2:0][7:0] chars;
        char_count_t     count;
        logic            escaped;
        logic            flag;
    } encoded_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] result;
        if (nib < 4'd10)
        begin
            result = CHAR_ZERO + {4'b0000, nib};
        end
        else
        begin
            result = CHAR_A_UC + {4'b0000, nib} - 8'd10;
        end
        return result;
    endfunction

endpackage

### design/upe_encode.sv
// upe_encode: classifies one byte against the escape mode and forms its 1 or 3 output chars.
// Combinational only; depends on upe_pkg.
module upe_encode (
    input  logic [7:0]             byte_in,
    input  upe_pkg::escape_mode_t  mode,
    input  logic                   seen,
    output upe_pkg::encoded_t      enc
);

    logic is_alnum;
    logic is_mark;
    logic is_reserved;
    logic res_escape;
    logic needs_escape;

    always_comb
    begin
        is_alnum = (byte_in >= 8'h41 && byte_in <= 8'h5A)
                || (byte_in >= 8'h61 && byte_in <= 8'h7A)
                || (byte_in >= 8'h30 && byte_in <= 8'h39);
        // - _ . ~
        is_mark = (byte_in == 8'h2D) || (byte_in == 8'h5F)
               || (byte_in == 8'h2E) || (byte_in == 8'h7E);
        // $ & + , / : ; = ? @
        is_reserved = (byte_in == 8'h24) || (byte_in == 8'h26) || (byte_in == 8'h2B)
                   || (byte_in == 8'h2C) || (byte_in == 8'h2F) || (byte_in == 8'h3A)
                   || (byte_in == 8'h3B) || (byte_in == 8'h3D) || (byte_in == 8'h3F)
                   || (byte_in == 8'h40);

        unique case (mode)
            upe_pkg::MODE_PATH:     res_escape = (byte_in == 8'h3F);
            upe_pkg::MODE_USERINFO: res_escape = (byte_in == 8'h40) || (byte_in == 8'h2F)
                                              || (byte_in == 8'h3A);
            upe_pkg::MODE_QUERY:    res_escape = 1'b1;
            upe_pkg::MODE_FRAGMENT: res_escape = 1'b0;
            default:                res_escape = 1'b0;
        endcase

        priority if (is_alnum || is_mark)
        begin
            needs_escape = 1'b0;
        end
        else if (is_reserved)
        begin
            needs_escape = res_escape;
        end
        else
        begin
            needs_escape = 1'b1;
        end

        enc.escaped = needs_escape;
        priority if (!needs_escape)
        begin
            enc.chars = {8'h00, 8'h00, byte_in};
            enc.count = upe_pkg::COUNT_SINGLE;
            enc.flag  = seen;
        end
        else if (byte_in == upe_pkg::CHAR_SPACE && mode == upe_pkg::MODE_QUERY)
        begin
            enc.chars = {8'h00, 8'h00, upe_pkg::CHAR_PLUS};
            enc.count = upe_pkg::COUNT_SINGLE;
            enc.flag  = 1'b1;
        end
        else
        begin
            enc.chars = {upe_pkg::hex_digit(byte_in[3:0]),
                         upe_pkg::hex_digit(byte_in[7:4]),
                         upe_pkg::CHAR_PCT};
            enc.count = upe_pkg::COUNT_TRIPLE;
            enc.flag  = 1'b1;
        end
    end

endmodule

### design/upe_emit.sv
// upe_emit: result register that holds one encoded byte and shifts its chars out one per beat.
// Depends on upe_pkg.
module upe_emit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  upe_pkg::encoded_t enc,
    input  logic              last_in,
    input  logic              out_stall,
    output logic              can_load,
    output logic              out_valid,
    output logic [7:0]        out_char,
    output logic              out_last,
    output logic              any_escaped
);

    upe_pkg::char_count_t count_reg, count_next;
    logic [2:0][7:0]      chars_reg, chars_next;
    logic                 last_reg, last_next;
    logic                 flag_reg, flag_next;
    logic                 beat;

    assign beat     = (count_reg != upe_pkg::COUNT_NONE) && !out_stall;
    // take a new byte when empty or when the final char leaves this cycle
    assign can_load = (count_reg == upe_pkg::COUNT_NONE)
                   || (count_reg == upe_pkg::COUNT_SINGLE && !out_stall);

    always_comb
    begin
        count_next = count_reg;
        chars_next = chars_reg;
        last_next  = last_reg;
        flag_next  = flag_reg;
        priority if (load)
        begin
            count_next = enc.count;
            chars_next = enc.chars;
            last_next  = last_in;
            flag_next  = enc.flag;
        end
        else if (beat)
        begin
            count_next = count_reg - 2'd1;
            chars_next = {8'h00, chars_reg[2], chars_reg[1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= upe_pkg::COUNT_NONE;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chars_reg <= chars_next;
        last_reg  <= last_next;
        flag_reg  <= flag_next;
    end

    assign out_valid   = (count_reg != upe_pkg::COUNT_NONE);
    assign out_char    = chars_reg[0];
    assign out_last    = last_reg && (count_reg == upe_pkg::COUNT_SINGLE);
    assign any_escaped = flag_reg;

    // a pair follows the percent beat of a triple, or is held under stall
    a_pair_from_triple: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == upe_pkg::COUNT_PAIR |->
            ($past(count_reg) == upe_pkg::COUNT_TRIPLE
             || $past(count_reg) == upe_pkg::COUNT_PAIR))
        else $error("emit count reached two without a triple");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (count_reg == upe_pkg::COUNT_NONE || count_reg == upe_pkg::COUNT_SINGLE))
        else $error("emit loaded over pending chars");

    a_triple_starts_pct: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == upe_pkg::COUNT_TRIPLE |-> chars_reg[0] == upe_pkg::CHAR_PCT && flag_reg)
        else $error("escape sequence does not start with percent");

endmodule

### design/url_percent_escape.sv
// url_percent_escape: top level of the URL percent-escape encoder.
// Depends on upe_pkg, upe_encode and upe_emit.
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid, in_stall, in_byte, in_last | byte stream in
//  out     | out_valid, out_stall, out_char,      | char stream out
//          | out_last, any_escaped                |
//  cfg     | cfg_we, cfg_wdata                    | escape mode write
//
// A byte waits in the input register until the result register can take it, then its 1 or 3 chars
// leave the result register one per beat: 1 char per unescaped byte or '+', 3 per %XX escape.
// The result channel is the limit; the next byte is encoded while the last char
// of the previous one is shown. Reset clears the valid flags, the sticky escape
// flag and sets path mode. An out stall backs up into in_stall without loss.
module url_percent_escape (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       out_last,
    output logic       any_escaped
);

    upe_pkg::escape_mode_t mode_reg;
    logic                  seen_reg, seen_next;
    logic                  s1_valid_reg, s1_valid_next;
    logic [7:0]            s1_byte_reg;
    logic                  s1_last_reg;
    logic                  in_beat;
    logic                  s1_take;
    logic                  can_load;
    upe_pkg::encoded_t     enc;

    assign s1_take  = s1_valid_reg && can_load;
    assign in_stall = s1_valid_reg && !can_load;
    assign in_beat  = in_valid && !in_stall;

    upe_encode u_encode (
        .byte_in (s1_byte_reg),
        .mode    (mode_reg),
        .seen    (seen_reg),
        .enc     (enc)
    );

    upe_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (s1_take),
        .enc         (enc),
        .last_in     (s1_last_reg),
        .out_stall   (out_stall),
        .can_load    (can_load),
        .out_valid   (out_valid),
        .out_char    (out_char),
        .out_last    (out_last),
        .any_escaped (any_escaped)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        seen_next     = seen_reg;
        if (s1_take)
        begin
            s1_valid_next = 1'b0;
            seen_next     = s1_last_reg ? 1'b0 : (seen_reg || enc.escaped);
        end
        if (in_beat)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= upe_pkg::MODE_PATH;
            seen_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= upe_pkg::escape_mode_t'(cfg_wdata);
            end
            seen_reg     <= seen_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            s1_byte_reg <= in_byte;
            s1_last_reg <= in_last;
        end
    end

    a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_take |=> s1_valid_reg && $stable(s1_byte_reg)
                                     && $stable(s1_last_reg))
        else $error("input register lost a pending byte");

    a_seen_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s1_take && s1_last_reg |=> !seen_reg)
        else $error("sticky escape flag not cleared after last byte");

    a_flag_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s1_take && seen_reg |=> any_escaped)
        else $error("escape flag dropped within a string");

endmodule

### test/url_percent_escape_tb.sv
// url_percent_escape_tb: self-checking bench for the URL percent-escape encoder.
// Depends on upe_pkg and url_percent_escape; predicts each output char per accepted byte
// and checks every char beat against it while the sender idles and the receiver stalls at random.
module url_percent_escape_tb;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } raw_beat_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       flag;
    } char_beat_t;

    localparam logic [8*16-1:0] HEX_DIGITS     = "0123456789ABCDEF";
    localparam logic [8*10-1:0] RESERVED_CHARS = "$&+,/:;=?@";
    localparam logic [8*4-1:0]  SAFE_MARKS     = "-_.~";

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       cfg_we      = 1'b0;
    logic [1:0] cfg_wdata   = 2'd0;
    logic       in_valid    = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte     = 8'd0;
    logic       in_last     = 1'b0;
    logic       out_valid;
    logic       out_stall   = 1'b0;
    logic [7:0] out_char;
    logic       out_last;
    logic       any_escaped;

    raw_beat_t             byte_queue[$];
    char_beat_t            expected_chars[$];
    upe_pkg::escape_mode_t cur_mode       = upe_pkg::MODE_PATH;
    logic                  string_escaped = 1'b0;
    int                    send_idle_pct  = 0;
    int                    recv_idle_pct  = 0;
    int                    error_count    = 0;

    url_percent_escape dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .in_last     (in_last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_char    (out_char),
        .out_last    (out_last),
        .any_escaped (any_escaped)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic escape_needed(input logic [7:0] data,
                                           input upe_pkg::escape_mode_t mode);
        logic result;
        if ((data >= "A" && data <= "Z") || (data >= "a" && data <= "z") ||
            (data >= "0" && data <= "9"))
        begin
            result = 1'b0;
        end
        else
        begin
            case (data)
                "-", "_", ".", "~":
                    result = 1'b0;
                "$", "&", "+", ",", "/", ":", ";", "=", "?", "@":
                    case (mode)
                        upe_pkg::MODE_PATH:     result = (data == "?");
                        upe_pkg::MODE_USERINFO: result = (data == "@" || data == "/"
                                                          || data == ":");
                        upe_pkg::MODE_QUERY:    result = 1'b1;
                        default:                result = 1'b0;
                    endcase
                default:
                    result = 1'b1;
            endcase
        end
        return result;
    endfunction

    function automatic logic [7:0] nibble_char(input logic [3:0] nib);
        return HEX_DIGITS[8 * (15 - nib) +: 8];
    endfunction

    // expected chars for one accepted byte, under the mode in force at acceptance
    task automatic predict_chars(input logic [7:0] data, input logic last);
        if (escape_needed(data, cur_mode))
        begin
            string_escaped = 1'b1;
            if (data == upe_pkg::CHAR_SPACE && cur_mode == upe_pkg::MODE_QUERY)
            begin
                expected_chars.push_back('{upe_pkg::CHAR_PLUS, last, 1'b1});
            end
            else
            begin
                expected_chars.push_back('{upe_pkg::CHAR_PCT, 1'b0, 1'b1});
                expected_chars.push_back('{nibble_char(data[7:4]), 1'b0, 1'b1});
                expected_chars.push_back('{nibble_char(data[3:0]), last, 1'b1});
            end
        end
        else
        begin
            expected_chars.push_back('{data, last, string_escaped});
        end
        if (last)
        begin
            string_escaped = 1'b0;
        end
    endtask

    function automatic logic [7:0] random_char();
        int         pick;
        logic [7:0] result;
        pick = $urandom_range(99);
        if (pick < 10)
            result = 8'("A" + $urandom_range(25));
        else if (pick < 20)
            result = 8'("a" + $urandom_range(25));
        else if (pick < 25)
            result = 8'("0" + $urandom_range(9));
        else if (pick < 35)
            result = SAFE_MARKS[8 * $urandom_range(3) +: 8];
        else if (pick < 60)
            result = RESERVED_CHARS[8 * $urandom_range(9) +: 8];
        else if (pick < 70)
            result = upe_pkg::CHAR_SPACE;
        else
            result = 8'($urandom_range(255));
        return result;
    endfunction

    task automatic queue_byte(input logic [7:0] data, input logic last);
        byte_queue.push_back('{data, last});
    endtask

    task automatic queue_text(input string text, input logic close_string);
        for (int i = 0; i < text.len(); i++)
        begin
            queue_byte(text[i], close_string && (i == text.len() - 1));
        end
    endtask

    // strings of random length; a phase may end with a string still open
    task automatic queue_random(input int count);
        int left;
        left = 0;
        for (int i = 0; i < count; i++)
        begin
            if (left == 0)
            begin
                left = ($urandom_range(9) == 0) ? $urandom_range(1, 30) : $urandom_range(1, 6);
            end
            left--;
            queue_byte(random_char(), left == 0);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (byte_queue.size() != 0 || in_valid || expected_chars.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_mode(input upe_pkg::escape_mode_t mode);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_mode  = mode;
        @(negedge clk);
    endtask

    // driver: a stalled beat is held; otherwise the next byte goes out unless idling
    always @(posedge clk)
    begin : driver
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_chars(in_byte, in_last);
                void'(byte_queue.pop_front());
            end
            if (!(in_valid && in_stall))
            begin
                if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_byte  <= byte_queue[0].data;
                    in_last  <= byte_queue[0].last;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        char_beat_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_chars.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected char beat: %h last %b flag %b",
                                 out_char, out_last, any_escaped);
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (out_char !== want.ch || out_last !== want.last ||
                        any_escaped !== want.flag)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display("char mismatch: expected %h/%b/%b got %h/%b/%b",
                                     want.ch, want.last, want.flag,
                                     out_char, out_last, any_escaped);
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial
    begin
        #2000000;
        $display("url_percent_escape regression: fail");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 37;
        recv_idle_pct = 49;
        @(negedge clk);

        // path mode from reset: of the reserved chars only '?' escapes; space, NUL and 0xFF go to %XX,
        // the flag stays up on later plain chars, and the string is left open
        queue_text("a?b/ ", 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_text("-_.~Z09z", 1'b0);
        wait_drained();

        // switch to query mode mid-string: space turns into '+', the flag clears at the end
        write_mode(upe_pkg::MODE_QUERY);
        queue_text(" &$=A", 1'b1);
        queue_text("q", 1'b1);
        queue_text(" ", 1'b1);
        wait_drained();

        for (int p = 0; p < 6; p++)
        begin
            if (p < 2)
            begin
                send_idle_pct = 37;
                recv_idle_pct = 49;
            end
            else if (p < 4)
            begin
                send_idle_pct = 49;
                recv_idle_pct = 37;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_mode(upe_pkg::escape_mode_t'((p + 1) % 4));
            queue_random(75);
            wait_drained();
        end

        repeat (10) @(posedge clk);
        error_count += expected_chars.size();
        if (error_count == 0)
            $display("url_percent_escape regression: pass");
        else
            $display("url_percent_escape regression: fail");
        $finish;
    end

endmodule
